FILE: rtl/core/cnls_pkg.sv
package cnls_pkg;

  // Default table geometry
  localparam int ROW_COUNT_DEF  = 6;
  localparam int ROW_LENGTH_DEF = 128;

  // Last index of a two-threshold walk before the cut to the row end
  localparam logic [7:0] DUAL_LAST = 8'h71;

  // Item operations
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_SPACING_TWO = 2'd0;
  localparam logic [1:0] REG_SPACING_ONE = 2'd1;
  localparam logic [1:0] REG_LAW_SELECT  = 2'd2;

  // Search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_THRESH,
    ST_WALK,
    ST_ENC
  } state_t;

endpackage

FILE: rtl/core/cnls_in_if.sv
interface cnls_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [2:0]         row;
  logic [6:0]         entry_index;
  logic signed [15:0] level;
  logic signed [15:0] alt_level;
  logic               two_threshold;

  modport source (
    output valid, op, row, entry_index, level, alt_level, two_threshold,
    input  ready
  );
  modport sink (
    input  valid, op, row, entry_index, level, alt_level, two_threshold,
    output ready
  );
endinterface

FILE: rtl/core/cnls_out_if.sv
interface cnls_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] stop_index;
  logic [6:0] level_code;
  logic       inside_row;

  modport source (
    output valid, stop_index, level_code, inside_row,
    input  ready
  );
  modport sink (
    input  valid, stop_index, level_code, inside_row,
    output ready
  );
endinterface

FILE: rtl/core/constellation_next_level_search.sv
// Constellation next-level search. Load words (op 0) write one entry of the
// main and alternate level tables and give no result. Search words (op 1)
// walk the main table of one row from the start index, one table read per
// cycle from a single-port memory, comparing each level against thresholds
// formed from the start entry. A search with a row or index out of range
// skips the walk. The single memory read port is shared by threshold fetch
// and walk. The input is not ready while a search runs; a finished result
// waits in an output register while the next word is taken.
module constellation_next_level_search #(
  parameter int ROW_COUNT  = cnls_pkg::ROW_COUNT_DEF,
  parameter int ROW_LENGTH = cnls_pkg::ROW_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cnls_in_if.sink     item,
  cnls_out_if.source  result,
  input  logic        write_enable,
  input  logic [1:0]  reg_index,
  input  logic [15:0] write_data
);

  localparam int         DEPTH     = ROW_COUNT * ROW_LENGTH;
  localparam int         AW        = $clog2(DEPTH);
  localparam logic [7:0] ROW_LEN_W = 8'(ROW_LENGTH);
  localparam logic [4:0] ROW_CNT_W = 5'(ROW_COUNT);
  localparam logic [7:0] LAST_ONE  = 8'(ROW_LENGTH - 1);
  localparam logic [7:0] LAST_TWO  =
    (cnls_pkg::DUAL_LAST < LAST_ONE) ? cnls_pkg::DUAL_LAST : LAST_ONE;

  cnls_pkg::state_t state, state_next;

  logic [15:0]        spacing_two;
  logic [15:0]        spacing_one;
  logic               law_select;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rdata;
  logic               mem_we;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         rd_idx;

  logic               in_fire;
  logic               in_ok;
  logic [AW-1:0]      in_addr;
  logic [AW-1:0]      in_base;

  logic [7:0]         cmp_idx;
  logic [AW-1:0]      row_base;
  logic               dual;
  logic               blank;
  logic signed [17:0] thr_a;
  logic signed [17:0] thr_b;
  logic signed [17:0] cur;
  logic signed [17:0] lvl_x;
  logic signed [17:0] alt_x;
  logic signed [17:0] sp_x;
  logic [7:0]         last_idx;
  logic               walk_stop;
  logic [7:0]         stop_idx;
  logic [15:0]        stop_level;
  logic [15:0]        stop_mag;
  logic               stop_inside;
  logic [6:0]         enc_code;
  logic               out_free;

  logic               res_valid;
  logic [7:0]         out_stop;
  logic [6:0]         out_code;
  logic               out_inside;

  // Decode the incoming word
  assign in_fire = item.valid && item.ready;
  assign in_ok   = ({2'b00, item.row} < ROW_CNT_W) && ({1'b0, item.entry_index} < ROW_LEN_W);
  assign in_base = AW'(int'(item.row) * ROW_LENGTH);
  assign in_addr = AW'(int'(item.row) * ROW_LENGTH + int'(item.entry_index));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_two <= '0;
      spacing_one <= '0;
      law_select  <= 1'b0;
    end else if (write_enable) begin
      case (reg_index)
        cnls_pkg::REG_SPACING_TWO: spacing_two <= write_data;
        cnls_pkg::REG_SPACING_ONE: spacing_one <= write_data;
        cnls_pkg::REG_LAW_SELECT:  law_select  <= write_data[0];
        default: ;
      endcase
    end
  end

  // Level tables: alternate level in the upper half of each word
  always_ff @(posedge clk) begin
    if (mem_we) mem[in_addr] <= {item.alt_level, item.level};
    if (rd_en) rdata <= mem[rd_addr];
  end

  // Walk compare unit
  assign rd_idx    = (state == cnls_pkg::ST_WALK) ? 8'(cmp_idx + 8'd1) : cmp_idx;
  assign rd_addr   = (state == cnls_pkg::ST_IDLE) ? in_addr : AW'(row_base + AW'(rd_idx));
  assign cur       = {{2{rdata[15]}}, rdata[15:0]};
  assign lvl_x     = {{2{rdata[15]}}, rdata[15:0]};
  assign alt_x     = {{2{rdata[31]}}, rdata[31:16]};
  assign sp_x      = dual ? {{2{spacing_two[15]}}, spacing_two}
                          : {{2{spacing_one[15]}}, spacing_one};
  assign last_idx  = dual ? LAST_TWO : LAST_ONE;
  assign walk_stop = (cmp_idx > last_idx) || ((cur >= thr_a) && (cur >= thr_b));
  assign out_free  = !res_valid || result.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cnls_pkg::ST_IDLE: begin
        if (in_fire && item.op == cnls_pkg::OP_SEARCH)
          state_next = in_ok ? cnls_pkg::ST_THRESH : cnls_pkg::ST_ENC;
      end
      cnls_pkg::ST_THRESH: state_next = cnls_pkg::ST_WALK;
      cnls_pkg::ST_WALK: begin
        if (walk_stop) state_next = cnls_pkg::ST_ENC;
      end
      cnls_pkg::ST_ENC: begin
        if (out_free) state_next = cnls_pkg::ST_IDLE;
      end
      default: state_next = cnls_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    item.ready = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    case (state)
      cnls_pkg::ST_IDLE: begin
        item.ready = 1'b1;
        mem_we     = in_fire && item.op == cnls_pkg::OP_LOAD && in_ok;
        rd_en      = in_fire && item.op == cnls_pkg::OP_SEARCH && in_ok;
      end
      cnls_pkg::ST_THRESH, cnls_pkg::ST_WALK: rd_en = rd_idx < ROW_LEN_W;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cnls_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Search datapath: latch the start, form thresholds, advance the walk, record the stop
  always_ff @(posedge clk) begin
    case (state)
      cnls_pkg::ST_IDLE: begin
        if (in_fire && item.op == cnls_pkg::OP_SEARCH) begin
          cmp_idx  <= {1'b0, item.entry_index};
          stop_idx <= {1'b0, item.entry_index};
          row_base <= in_base;
          dual     <= item.two_threshold;
          blank    <= !in_ok;
        end
      end
      cnls_pkg::ST_THRESH: begin
        thr_a <= lvl_x + sp_x;
        thr_b <= dual ? (alt_x + sp_x) : (lvl_x + sp_x);
      end
      cnls_pkg::ST_WALK: begin
        if (walk_stop) begin
          stop_idx   <= cmp_idx;
          stop_level <= rdata[15:0];
        end else begin
          cmp_idx <= 8'(cmp_idx + 8'd1);
        end
      end
      default: ;
    endcase
  end

  // Encode the stop level magnitude
  assign stop_mag    = stop_level[15] ? 16'(-stop_level) : stop_level;
  assign stop_inside = !blank && (stop_idx < ROW_LEN_W);

  cnls_g711_enc u_enc (
    .mag  (stop_mag),
    .law  (law_select),
    .code (enc_code)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == cnls_pkg::ST_ENC && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cnls_pkg::ST_ENC && out_free) begin
      out_stop   <= stop_idx;
      out_code   <= stop_inside ? enc_code : 7'd0;
      out_inside <= stop_inside;
    end
  end

  assign result.valid      = res_valid;
  assign result.stop_index = out_stop;
  assign result.level_code = out_code;
  assign result.inside_row = out_inside;

  // Checks
  assert property (@(posedge clk) disable iff (rst)
    res_valid && out_inside |-> out_stop < ROW_LEN_W)
    else $error("inside_row set with stop past the row end");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_inside |-> out_code == 7'd0)
    else $error("nonzero code on a stop outside the row");

  assert property (@(posedge clk) disable iff (rst)
    state == cnls_pkg::ST_WALK |-> cmp_idx <= ROW_LEN_W)
    else $error("walk ran past the row end");

  assert property (@(posedge clk) disable iff (rst)
    in_fire && item.op == cnls_pkg::OP_LOAD |=>
      state == cnls_pkg::ST_IDLE && !$rose(res_valid))
    else $error("load word started a search or produced a result");

endmodule

FILE: rtl/core/cnls_g711_enc.sv
module cnls_g711_enc (
  input  logic [15:0] mag,
  input  logic        law,
  output logic [6:0]  code
);

  logic [12:0] a_v;
  logic [3:0]  a_seg;
  logic [2:0]  a_shift;
  logic [3:0]  a_step;
  logic [6:0]  a_code;
  logic [13:0] u_c;
  logic [13:0] u_v;
  logic [3:0]  u_seg;
  logic [3:0]  u_shift;
  logic [3:0]  u_step;
  logic [6:0]  u_code;

  // A-law: segment is the count of segment ends at or below the scaled magnitude
  always_comb begin
    a_v   = mag[15:3];
    a_seg = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if ({1'b0, a_v} >= (14'd32 << k)) a_seg = a_seg + 4'd1;
    end
    a_shift = (a_seg < 4'd2) ? 3'd1 : a_seg[2:0];
    a_step  = 4'(a_v >> a_shift);
    a_code  = a_seg[3] ? 7'h7F : {a_seg[2:0], a_step};
  end

  // mu-law: clip, add bias, then find the segment
  always_comb begin
    u_c   = mag[15:2];
    if (u_c > 14'd8159) u_c = 14'd8159;
    u_v   = u_c + 14'h21;
    u_seg = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if ({1'b0, u_v} >= (15'd64 << k)) u_seg = u_seg + 4'd1;
    end
    u_shift = {1'b0, u_seg[2:0]} + 4'd1;
    u_step  = 4'(u_v >> u_shift);
    u_code  = u_seg[3] ? 7'h7F : {u_seg[2:0], u_step};
  end

  assign code = law ? a_code : u_code;

endmodule

FILE: dv/tb_constellation_next_level_search.sv
`timescale 1ns / 1ps

module tb_constellation_next_level_search;

  // One input word as the testbench sees it
  typedef struct packed {
    logic        op;
    logic [2:0]  row;
    logic [6:0]  entry_index;
    logic [15:0] level;
    logic [15:0] alt_level;
    logic        two_threshold;
  } level_word_t;

  // One result word
  typedef struct packed {
    logic [7:0] stop_index;
    logic [6:0] level_code;
    logic       inside_row;
  } search_result_t;

  // One step of the directed sequence: a register write or a word
  typedef struct packed {
    logic           is_reg;
    logic [1:0]     reg_sel;
    logic [15:0]    reg_value;
    level_word_t    word;
    logic           typed;
    search_result_t typed_result;
  } plan_row_t;

  typedef struct packed {
    logic [15:0] level;
    logic [15:0] alt;
  } level_pair_t;

  localparam level_word_t    NO_WORD   = '0;
  localparam search_result_t NO_RESULT = '0;

  logic        clk;
  logic        rst;
  logic        write_enable;
  logic [1:0]  reg_index;
  logic [15:0] write_data;

  cnls_in_if  item_bus ();
  cnls_out_if result_bus ();

  constellation_next_level_search u_top (
    .clk          (clk),
    .rst          (rst),
    .item         (item_bus),
    .result       (result_bus),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  // Shadow copy of the tables and registers
  logic signed [15:0] main_levels [cnls_pkg::ROW_COUNT_DEF][cnls_pkg::ROW_LENGTH_DEF];
  logic signed [15:0] alt_levels  [cnls_pkg::ROW_COUNT_DEF][cnls_pkg::ROW_LENGTH_DEF];
  logic signed [15:0] spacing_two_q;
  logic signed [15:0] spacing_one_q;
  logic               a_law_q;

  search_result_t pending_results [$];
  int             mismatch_count;
  int             burst_left;

  // Directed sequence: extremes, ignored loads, out-of-range rows, bounds
  plan_row_t directed_plan [30] = '{
    '{1'b1, cnls_pkg::REG_SPACING_ONE, 16'h7fff, NO_WORD, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_LOAD, 3'd5, 7'd127, 16'h0001, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd5, 7'd127, 16'h0000, 16'h0000, 1'b0},
      1'b1, '{8'd128, 7'h00, 1'b0}},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd6, 7'd5, 16'hffff, 16'hffff, 1'b0},
      1'b1, '{8'd5, 7'h00, 1'b0}},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd7, 7'd127, 16'h0000, 16'h0000, 1'b1},
      1'b1, '{8'd127, 7'h00, 1'b0}},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_LOAD, 3'd7, 7'd0, 16'h7fff, 16'h8000, 1'b1}, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_LOAD, 3'd6, 7'd127, 16'h8000, 16'h7fff, 1'b0}, 1'b0, NO_RESULT},
    '{1'b1, cnls_pkg::REG_SPACING_ONE, 16'h0000, NO_WORD, 1'b0, NO_RESULT},
    '{1'b1, cnls_pkg::REG_SPACING_TWO, 16'h0000, NO_WORD, 1'b0, NO_RESULT},
    '{1'b1, cnls_pkg::REG_LAW_SELECT, 16'h0000, NO_WORD, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_LOAD, 3'd4, 7'd10, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd4, 7'd10, 16'h0000, 16'h0000, 1'b0},
      1'b1, '{8'd10, 7'h00, 1'b1}},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_LOAD, 3'd4, 7'd11, 16'h8000, 16'h8000, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd4, 7'd11, 16'h0000, 16'h0000, 1'b0},
      1'b1, '{8'd11, 7'h7f, 1'b1}},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_LOAD, 3'd4, 7'd12, 16'h7fff, 16'h7fff, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd4, 7'd12, 16'h0000, 16'h0000, 1'b0},
      1'b1, '{8'd12, 7'h7f, 1'b1}},
    '{1'b1, cnls_pkg::REG_LAW_SELECT, 16'h0001, NO_WORD, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd4, 7'd11, 16'h0000, 16'h0000, 1'b0},
      1'b1, '{8'd11, 7'h7f, 1'b1}},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd4, 7'd10, 16'h0000, 16'h0000, 1'b1},
      1'b1, '{8'd10, 7'h00, 1'b1}},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd3, 7'd120, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd3, 7'd113, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_RESULT},
    '{1'b1, cnls_pkg::REG_SPACING_TWO, 16'h7fff, NO_WORD, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd1, 7'd0, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd0, 7'd0, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_RESULT},
    '{1'b1, cnls_pkg::REG_SPACING_TWO, 16'h8000, NO_WORD, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd2, 7'd50, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_RESULT},
    '{1'b1, cnls_pkg::REG_SPACING_ONE, 16'h8000, NO_WORD, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd0, 7'd127, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RESULT},
    '{1'b1, cnls_pkg::REG_SPACING_ONE, 16'h0200, NO_WORD, 1'b0, NO_RESULT},
    '{1'b0, cnls_pkg::REG_SPACING_TWO, 16'h0000,
      '{cnls_pkg::OP_SEARCH, 3'd1, 7'd0, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RESULT}
  };

  // A-law magnitude code, sign bit dropped
  function automatic logic [6:0] alaw_code(input int mag);
    int v;
    int seg;
    int code;
    v = mag >> 3;
    seg = 0;
    while (seg < 8 && v > (32 << seg) - 1) seg++;
    if (seg >= 8) begin
      code = 'h7f;
    end else if (seg < 2) begin
      code = (seg << 4) | ((v >> 1) & 15);
    end else begin
      code = (seg << 4) | ((v >> seg) & 15);
    end
    return code[6:0];
  endfunction

  // mu-law magnitude code, sign bit dropped
  function automatic logic [6:0] mulaw_code(input int mag);
    int v;
    int seg;
    int code;
    v = mag >> 2;
    if (v > 8159) v = 8159;
    v = v + 33;
    seg = 0;
    while (seg < 8 && v > (64 << seg) - 1) seg++;
    if (seg >= 8) begin
      code = 'h7f;
    end else begin
      code = (seg << 4) | ((v >> (seg + 1)) & 15);
    end
    return code[6:0];
  endfunction

  // Walk the shadow table and form the result of one search word
  function automatic search_result_t search_outcome(input level_word_t w);
    search_result_t r;
    int pos;
    int last;
    int lo;
    int lo_alt;
    int v;
    r.stop_index = {1'b0, w.entry_index};
    r.level_code = '0;
    r.inside_row = 1'b0;
    if (w.row >= cnls_pkg::ROW_COUNT_DEF || w.entry_index >= cnls_pkg::ROW_LENGTH_DEF)
      return r;
    pos = w.entry_index;
    if (w.two_threshold) begin
      lo     = int'(main_levels[w.row][pos]) + int'(spacing_two_q);
      lo_alt = int'(alt_levels[w.row][pos]) + int'(spacing_two_q);
      last   = (int'(cnls_pkg::DUAL_LAST) < cnls_pkg::ROW_LENGTH_DEF - 1) ?
               int'(cnls_pkg::DUAL_LAST) : cnls_pkg::ROW_LENGTH_DEF - 1;
      while (pos <= last) begin
        v = main_levels[w.row][pos];
        if (v >= lo && v >= lo_alt) break;
        pos++;
      end
    end else begin
      lo   = int'(main_levels[w.row][pos]) + int'(spacing_one_q);
      last = cnls_pkg::ROW_LENGTH_DEF - 1;
      while (pos <= last) begin
        v = main_levels[w.row][pos];
        if (v >= lo) break;
        pos++;
      end
    end
    r.stop_index = pos[7:0];
    if (pos < cnls_pkg::ROW_LENGTH_DEF) begin
      v = main_levels[w.row][pos];
      if (v < 0) v = -v;
      r.inside_row = 1'b1;
      r.level_code = a_law_q ? alaw_code(v) : mulaw_code(v);
    end
    return r;
  endfunction

  // Table contents by row: ramps up and down, random, small, extremes, noisy ramp
  function automatic level_pair_t shaped_pair(input int row, input int idx);
    level_pair_t p;
    int lv;
    int al;
    case (row)
      0: lv = idx * 512 - 32768 + int'($urandom_range(0, 127)) - 64;
      1: lv = 32767 - idx * 512 + int'($urandom_range(0, 127)) - 64;
      3: lv = int'($urandom_range(0, 255)) - 128;
      4: begin
        case ($urandom_range(0, 5))
          0: lv = -32768;
          1: lv = 32767;
          2: lv = 0;
          3: lv = -1;
          4: lv = 1;
          default: lv = int'($urandom_range(0, 65535)) - 32768;
        endcase
      end
      5: lv = idx * 256 - 16384 + int'($urandom_range(0, 4095)) - 2048;
      default: lv = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (lv > 32767) lv = 32767;
    if (lv < -32768) lv = -32768;
    case ($urandom_range(0, 3))
      0: al = int'($urandom_range(0, 65535)) - 32768;
      1: al = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
      default: al = lv + int'($urandom_range(0, 2047)) - 1024;
    endcase
    if (al > 32767) al = 32767;
    if (al < -32768) al = -32768;
    p.level = lv[15:0];
    p.alt   = al[15:0];
    return p;
  endfunction

  // Spacing values: extremes, zero, ramp steps, small and full random
  function automatic logic [15:0] pick_spacing();
    int s;
    case ($urandom_range(0, 5))
      0: s = 32767;
      1: s = -32768;
      2: s = 0;
      3: s = int'($urandom_range(0, 64)) * 512 - 4096;
      4: s = int'($urandom_range(0, 4095)) - 2048;
      default: s = int'($urandom_range(0, 65535));
    endcase
    return s[15:0];
  endfunction

  // Offer one word in bursts with random gaps; update the shadow on accept
  task automatic send_word(input level_word_t w, input logic typed,
                           input search_result_t typed_result);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap != 0) begin
      @(negedge clk);
      item_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_bus.valid         <= 1'b1;
    item_bus.op            <= w.op;
    item_bus.row           <= w.row;
    item_bus.entry_index   <= w.entry_index;
    item_bus.level         <= w.level;
    item_bus.alt_level     <= w.alt_level;
    item_bus.two_threshold <= w.two_threshold;
    @(posedge clk);
    while (item_bus.ready !== 1'b1) @(posedge clk);
    if (w.op == cnls_pkg::OP_LOAD) begin
      if (w.row < cnls_pkg::ROW_COUNT_DEF && w.entry_index < cnls_pkg::ROW_LENGTH_DEF) begin
        main_levels[w.row][w.entry_index] = w.level;
        alt_levels[w.row][w.entry_index]  = w.alt_level;
      end
    end else begin
      pending_results.push_back(typed ? typed_result : search_outcome(w));
    end
  endtask

  // Write one register once the block has gone quiet
  task automatic write_reg(input logic [1:0] sel, input logic [15:0] value);
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    write_enable <= 1'b1;
    reg_index    <= sel;
    write_data   <= value;
    @(negedge clk);
    write_enable <= 1'b0;
    case (sel)
      cnls_pkg::REG_SPACING_TWO: spacing_two_q = value;
      cnls_pkg::REG_SPACING_ONE: spacing_one_q = value;
      cnls_pkg::REG_LAW_SELECT:  a_law_q = value[0];
      default: ;
    endcase
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #(64'd10_000_000);
    $display("Mismatches found");
    $finish;
  end

  // Receiver: stall on a pattern that is chosen anew at random
  initial begin
    int stall_mode;
    int mode_left;
    stall_mode = 0;
    mode_left  = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 200);
      end
      mode_left--;
      case (stall_mode)
        0: result_bus.ready <= 1'b1;
        1: result_bus.ready <= ($urandom_range(0, 1) == 1);
        2: result_bus.ready <= ($urandom_range(0, 3) == 0);
        default: result_bus.ready <= (mode_left % 3 != 0);
      endcase
    end
  end

  // Compare each accepted result word with the oldest expected one
  always @(posedge clk) begin
    search_result_t got;
    search_result_t want;
    if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      got = {result_bus.stop_index, result_bus.level_code, result_bus.inside_row};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: stop %0d code %h inside %b",
                   got.stop_index, got.level_code, got.inside_row);
      end else begin
        want = pending_results.pop_front();
        if (got.stop_index !== want.stop_index || got.level_code !== want.level_code ||
            got.inside_row !== want.inside_row) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: want stop %0d code %h inside %b, got stop %0d code %h inside %b",
                     want.stop_index, want.level_code, want.inside_row,
                     got.stop_index, got.level_code, got.inside_row);
        end
      end
    end
  end

  // Stimulus
  initial begin
    level_word_t w;
    level_pair_t pair;
    int row_pick;
    int idx_pick;
    mismatch_count = 0;
    burst_left     = 0;
    spacing_two_q  = '0;
    spacing_one_q  = '0;
    a_law_q        = 1'b0;
    rst            = 1'b1;
    write_enable   = 1'b0;
    reg_index      = cnls_pkg::REG_SPACING_TWO;
    write_data     = '0;
    item_bus.valid         = 1'b0;
    item_bus.op            = cnls_pkg::OP_LOAD;
    item_bus.row           = '0;
    item_bus.entry_index   = '0;
    item_bus.level         = '0;
    item_bus.alt_level     = '0;
    item_bus.two_threshold = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill every entry first so that no walk reads an unloaded one
    for (int r = 0; r < cnls_pkg::ROW_COUNT_DEF; r++) begin
      for (int i = 0; i < cnls_pkg::ROW_LENGTH_DEF; i++) begin
        pair = shaped_pair(r, i);
        w = '{cnls_pkg::OP_LOAD, r[2:0], i[6:0], pair.level, pair.alt, i[0]};
        send_word(w, 1'b0, NO_RESULT);
      end
    end

    // Walk the directed sequence
    foreach (directed_plan[k]) begin
      if (directed_plan[k].is_reg)
        write_reg(directed_plan[k].reg_sel, directed_plan[k].reg_value);
      else
        send_word(directed_plan[k].word, directed_plan[k].typed,
                  directed_plan[k].typed_result);
    end

    // Random phases, each with fresh register settings
    for (int phase = 0; phase < 10; phase++) begin
      write_reg(cnls_pkg::REG_SPACING_TWO, pick_spacing());
      write_reg(cnls_pkg::REG_SPACING_ONE, pick_spacing());
      write_reg(cnls_pkg::REG_LAW_SELECT, {15'd0, phase[0]});
      for (int n = 0; n < 110; n++) begin
        row_pick = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 6))
            0: idx_pick = 0;
            1: idx_pick = 112;
            2: idx_pick = 113;
            3: idx_pick = 114;
            4: idx_pick = 115;
            5: idx_pick = 126;
            default: idx_pick = 127;
          endcase
        end else begin
          idx_pick = $urandom_range(0, 127);
        end
        w.op            = ($urandom_range(0, 9) < 4) ? cnls_pkg::OP_LOAD : cnls_pkg::OP_SEARCH;
        w.row           = row_pick[2:0];
        w.entry_index   = idx_pick[6:0];
        w.two_threshold = 1'($urandom_range(0, 1));
        if (w.op == cnls_pkg::OP_LOAD) begin
          pair = shaped_pair(row_pick, idx_pick);
          w.level     = pair.level;
          w.alt_level = pair.alt;
        end else begin
          w.level     = 16'($urandom_range(0, 65535));
          w.alt_level = 16'($urandom_range(0, 65535));
        end
        send_word(w, 1'b0, NO_RESULT);
      end
    end

    // Drop valid, drain the expected results, then wait before the verdict
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (cnls_pkg::ROW_LENGTH_DEF + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
